// ===== rtl/core/ps2mct_pkg.sv =====
// Package for the PS/2 mouse cursor tracker.
// Holds coordinate and size widths, register indexes, flag bit positions and
// the size limiting function. Depends on nothing.
package ps2mct_pkg;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int SUM_BITS   = COORD_BITS + 2;
   localparam int BYTE_BITS  = 8;
   localparam int CSR_BITS   = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam int WIDE_BITS  = (CSR_BITS > SIZE_BITS) ? CSR_BITS : SIZE_BITS;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [CSR_BITS-1:0] RESET_WIDTH  = CSR_BITS'(320);
   localparam logic [CSR_BITS-1:0] RESET_HEIGHT = CSR_BITS'(200);

   // Flags byte bit positions.
   localparam int FLAG_LEFT_BIT  = 0;
   localparam int FLAG_RIGHT_BIT = 1;
   localparam int FLAG_VALID_BIT = 3;

   // Largest usable screen size on one axis.
   localparam logic [WIDE_BITS-1:0] SIZE_CAP = WIDE_BITS'(1) << COORD_BITS;

   // A size of zero acts as one, and a size above the coordinate range is
   // cut down to the full coordinate range.
   function automatic logic [SIZE_BITS-1:0] effective_size(input logic [CSR_BITS-1:0] size_reg);
      logic [WIDE_BITS-1:0] wide_size;
      wide_size = WIDE_BITS'(size_reg);
      if (wide_size == '0) begin
         return SIZE_BITS'(1);
      end else if (wide_size > SIZE_CAP) begin
         return SIZE_BITS'(SIZE_CAP);
      end else begin
         return SIZE_BITS'(wide_size);
      end
   endfunction

endpackage

// ===== rtl/core/ps2mct_if.sv =====
// Valid/ready channel interfaces of the PS/2 mouse cursor tracker.
// ps2mct_req_if carries raw mouse bytes, ps2mct_rsp_if carries cursor items.
// Depends on ps2mct_pkg.
interface ps2mct_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2mct_pkg::BYTE_BITS-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ps2mct_pkg::COORD_BITS-1:0] cursor_x;
   logic [ps2mct_pkg::COORD_BITS-1:0] cursor_y;
   logic                            left_pressed;
   logic                            right_pressed;
   logic                            packet_applied;

   modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                   output right_pressed, output packet_applied, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                   input right_pressed, input packet_applied, output ready);
endinterface

// ===== rtl/core/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse cursor tracker, top level.
// Each accepted byte yields its cursor item on the rsp side in the next cycle.
// Throughput: one byte per cycle while the rsp side keeps up; the add and clamp
// of each axis is combinational logic in front of the result register.
// Reset (synchronous, active high) loads 320 x 200, centers the cursor,
// releases both buttons and restarts packet framing. Depends on ps2mct_pkg and ps2mct_if.
module ps2_mouse_cursor_tracker (
   input  logic                                clock,
   input  logic                                reset,
   ps2mct_req_if.sink                          req_if,
   ps2mct_rsp_if.source                        rsp_if,
   input  logic                                csr_wr_en,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mct_pkg::CSR_BITS-1:0]     csr_wdata
);
   import ps2mct_pkg::*;

   // Byte position codes within a three-byte packet.
   localparam logic [1:0] POS_FLAGS   = 2'd0;
   localparam logic [1:0] POS_X_DELTA = 2'd1;
   localparam logic [1:0] POS_Y_DELTA = 2'd2;

   // Configuration registers.
   logic [CSR_BITS-1:0]   width_ff, width_in;
   logic [CSR_BITS-1:0]   height_ff, height_in;

   // Packet framing and cursor state.
   logic [1:0]            byte_pos_ff, byte_pos_in;
   logic [BYTE_BITS-1:0]  flags_ff, flags_in;
   logic [BYTE_BITS-1:0]  x_delta_ff, x_delta_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic                  left_ff, left_in;
   logic                  right_ff, right_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  applied_ff, applied_in;

   logic                  accept;
   logic [CSR_BITS-1:0]   wr_width, wr_height;
   logic [SIZE_BITS-1:0]  eff_width, eff_height;
   logic [SIZE_BITS-1:0]  new_eff_width, new_eff_height;
   logic [SUM_BITS-1:0]   sum_x, sum_y;
   logic [COORD_BITS-1:0] clamp_x, clamp_y;
   logic                  packet_ok;

   // The result register frees up in the same cycle its item is taken, so a
   // new byte can enter every cycle while the rsp side keeps up.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign eff_width  = effective_size(width_ff);
   assign eff_height = effective_size(height_ff);

   // The sizes that a register write leaves behind, used to recenter.
   assign wr_width  = (csr_index == CSR_SCREEN_WIDTH) ? csr_wdata : width_ff;
   assign wr_height = (csr_index == CSR_SCREEN_HEIGHT) ? csr_wdata : height_ff;
   assign new_eff_width  = effective_size(wr_width);
   assign new_eff_height = effective_size(wr_height);

   // X moves right with a positive delta. Y is flipped because the mouse
   // reports up as positive while screen rows grow downward.
   assign sum_x = SUM_BITS'(pos_x_ff)
                + {{(SUM_BITS-BYTE_BITS){x_delta_ff[BYTE_BITS-1]}}, x_delta_ff};
   assign sum_y = SUM_BITS'(pos_y_ff)
                - {{(SUM_BITS-BYTE_BITS){req_if.data_byte[BYTE_BITS-1]}},
                   req_if.data_byte};

   // Clamp each axis into 0..size-1. The sum's top bit is its sign.
   always_comb begin
      if (sum_x[SUM_BITS-1]) begin
         clamp_x = '0;
      end else if (sum_x[SIZE_BITS-1:0] >= eff_width) begin
         clamp_x = COORD_BITS'(eff_width - SIZE_BITS'(1));
      end else begin
         clamp_x = sum_x[COORD_BITS-1:0];
      end
      if (sum_y[SUM_BITS-1]) begin
         clamp_y = '0;
      end else if (sum_y[SIZE_BITS-1:0] >= eff_height) begin
         clamp_y = COORD_BITS'(eff_height - SIZE_BITS'(1));
      end else begin
         clamp_y = sum_y[COORD_BITS-1:0];
      end
   end

   assign packet_ok = flags_ff[FLAG_VALID_BIT];

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      byte_pos_in  = byte_pos_ff;
      flags_in     = flags_ff;
      x_delta_in   = x_delta_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      applied_in   = applied_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      // Write configuration only while no item is in flight; the block does not enforce this.
      // Writing either size recenters both axes on the new effective sizes.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_SCREEN_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
         pos_x_in = new_eff_width[SIZE_BITS-1:1];
         pos_y_in = new_eff_height[SIZE_BITS-1:1];
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         applied_in   = 1'b0;
         case (byte_pos_ff)
            POS_FLAGS: begin
               flags_in    = req_if.data_byte;
               byte_pos_in = POS_X_DELTA;
            end
            POS_X_DELTA: begin
               x_delta_in  = req_if.data_byte;
               byte_pos_in = POS_Y_DELTA;
            end
            default: begin
               // Third byte: apply the packet only if its flags say valid.
               // Framing restarts either way.
               byte_pos_in = POS_FLAGS;
               if (packet_ok) begin
                  pos_x_in   = clamp_x;
                  pos_y_in   = clamp_y;
                  left_in    = flags_ff[FLAG_LEFT_BIT];
                  right_in   = flags_ff[FLAG_RIGHT_BIT];
                  applied_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RESET_WIDTH;
         height_ff    <= RESET_HEIGHT;
         byte_pos_ff  <= POS_FLAGS;
         pos_x_ff     <= COORD_BITS'(RESET_WIDTH >> 1);
         pos_y_ff     <= COORD_BITS'(RESET_HEIGHT >> 1);
         left_ff      <= 1'b0;
         right_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         byte_pos_ff  <= byte_pos_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stored packet bytes are always written before they are read.
   always_ff @(posedge clock) begin
      flags_ff   <= flags_in;
      x_delta_ff <= x_delta_in;
      applied_ff <= applied_in;
   end

   // The cursor state registers double as the result payload: between
   // accepted bytes they only change on a configuration write, which the user
   // must not make while an item waits on the rsp side (the block does not enforce this).
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.cursor_x       = pos_x_ff;
   assign rsp_if.cursor_y       = pos_y_ff;
   assign rsp_if.left_pressed   = left_ff;
   assign rsp_if.right_pressed  = right_ff;
   assign rsp_if.packet_applied = applied_ff;

endmodule
